// ===== sv/tcpq_pkg.sv =====
`default_nettype none

package tcpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_W        = 16;
	localparam int PREP_W      = 16;
	localparam int LIVE_W      = 5;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_ENQ    = 2'd0,
		CMD_DEQ    = 2'd1,
		CMD_CANCEL = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PREP_W-1:0] prep;
		logic              vip;
	} entry_t;

	// Broadcast from the top level to every cell
	typedef struct packed {
		cmd_t            op;
		logic            any_vip;
		logic [ID_W-1:0] key;
		entry_t          new_entry;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/tcpq_req_if.sv =====
`default_nettype none

interface tcpq_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  command;
	logic [tcpq_pkg::ID_W-1:0]   entry_id;
	logic [tcpq_pkg::PREP_W-1:0] prep_time;
	logic                        vip;

	modport source (output valid, command, entry_id, prep_time, vip, input ready);
	modport sink   (input valid, command, entry_id, prep_time, vip, output ready);
endinterface

`default_nettype wire

// ===== sv/tcpq_rsp_if.sv =====
`default_nettype none

interface tcpq_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [tcpq_pkg::ID_W-1:0]   out_id;
	logic [tcpq_pkg::PREP_W-1:0] out_prep;
	logic                        out_vip;
	logic [tcpq_pkg::LIVE_W-1:0] live_count;

	modport source (output valid, status, out_id, out_prep, out_vip, live_count,
		input ready);
	modport sink   (input valid, status, out_id, out_prep, out_vip, live_count,
		output ready);
endinterface

`default_nettype wire

// ===== sv/tcpq_cell.sv =====
`default_nettype none

// One queue position. Cells are kept packed in arrival order, oldest at cell 0.
module tcpq_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tcpq_pkg::cell_ctrl_t ctrl,
	input  wire logic                 found_in,
	input  wire logic                 prev_valid,
	input  wire logic                 nbr_valid,
	input  wire tcpq_pkg::entry_t     nbr_entry,
	output logic                      found_out,
	output logic                      remove,
	output logic                      valid,
	output logic                      vip_live,
	output tcpq_pkg::entry_t          entry
);

	logic             valid_q;
	tcpq_pkg::entry_t entry_q;
	logic             match;
	logic             load;

	// Compare this entry against the current operation
	always_comb begin
		unique case (ctrl.op)
			tcpq_pkg::CMD_DEQ:    match = valid_q & (entry_q.vip | ~ctrl.any_vip);
			tcpq_pkg::CMD_CANCEL: match = valid_q & (entry_q.id == ctrl.key);
			default:              match = 1'b0;
		endcase
	end

	// Only the oldest match is removed; every cell at or above it shifts down
	assign remove    = match & ~found_in;
	assign found_out = found_in | remove;
	assign load      = (ctrl.op == tcpq_pkg::CMD_ENQ) & ~valid_q & prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (found_out) begin
			valid_q <= nbr_valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (found_out) begin
			entry_q <= nbr_entry;
		end else if (load) begin
			entry_q <= ctrl.new_entry;
		end
	end

	assign valid    = valid_q;
	assign vip_live = valid_q & entry_q.vip;
	assign entry    = entry_q;

endmodule

`default_nettype wire

// ===== sv/two_class_priority_queue_cancel_top.sv =====
// A request accepted into the request stage is executed once the response register
// can take it; its response is registered there and then becomes valid.
// Throughput: one request per cycle while responses are taken; a response that
// waits holds the request stage and with it the request input.
// Reset: arst_n clears all entries, the count and both pipeline flags.
`default_nettype none

module two_class_priority_queue_cancel_top (
	input wire logic clk,
	input wire logic arst_n,
	tcpq_req_if.sink   req,
	tcpq_rsp_if.source rsp
);

	localparam int D = tcpq_pkg::QUEUE_DEPTH;

	logic                           busy_s1;
	tcpq_pkg::cmd_t                 cmd_s1;
	tcpq_pkg::entry_t               ent_s1;
	logic                           exec;
	logic [tcpq_pkg::CNT_W-1:0]     count_q;
	logic [tcpq_pkg::CNT_W-1:0]     count_next;
	logic                           full;
	logic                           empty;

	tcpq_pkg::cell_ctrl_t           ctrl;
	logic [D:0]                     found;
	logic [D-1:0]                   cell_valid;
	logic [D+1:0]                   valid_pad;
	logic [D-1:0]                   remove;
	logic [D-1:0]                   vip_live;
	tcpq_pkg::entry_t               entries [D+1];
	tcpq_pkg::entry_t               sel;

	tcpq_pkg::status_t              status_d;
	tcpq_pkg::entry_t               out_d;

	logic                           out_valid_q;
	tcpq_pkg::status_t              status_q;
	tcpq_pkg::entry_t               out_q;
	logic [tcpq_pkg::LIVE_W-1:0]    live_q;

	// Execute the held request when the response register can take it
	assign exec      = busy_s1 & (~out_valid_q | rsp.ready);
	assign req.ready = ~busy_s1 | exec;
	assign full      = (count_q == tcpq_pkg::CNT_W'(D));
	assign empty     = (count_q == '0);

	// Hold the accepted request for execution
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (req.ready) begin
			busy_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1      <= tcpq_pkg::cmd_t'(req.command);
			ent_s1.id   <= req.entry_id;
			ent_s1.prep <= req.prep_time;
			ent_s1.vip  <= req.vip;
		end
	end

	// Broadcast the operation to the cells
	always_comb begin
		ctrl.op        = exec ? cmd_s1 : tcpq_pkg::CMD_NOP;
		ctrl.any_vip   = |vip_live;
		ctrl.key       = ent_s1.id;
		ctrl.new_entry = ent_s1;
	end

	// Pad the valid row: always occupied ahead of cell 0, always empty past the last cell
	assign found[0]   = 1'b0;
	assign valid_pad  = {1'b0, cell_valid, 1'b1};
	assign entries[D] = '0;

	for (genvar i = 0; i < D; i++) begin : g_cell
		tcpq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.found_in   (found[i]),
			.prev_valid (valid_pad[i]),
			.nbr_valid  (valid_pad[i+2]),
			.nbr_entry  (entries[i+1]),
			.found_out  (found[i+1]),
			.remove     (remove[i]),
			.valid      (cell_valid[i]),
			.vip_live   (vip_live[i]),
			.entry      (entries[i])
		);
	end

	// Pick the removed entry; at most one cell removes
	always_comb begin
		sel = '0;
		for (int i = 0; i < D; i++) begin
			sel = sel | (remove[i] ? entries[i] : '0);
		end
	end

	// Build the response and the next count
	always_comb begin
		status_d   = tcpq_pkg::ST_OK;
		out_d      = '0;
		count_next = count_q;
		unique case (cmd_s1)
			tcpq_pkg::CMD_ENQ: begin
				if (full) begin
					status_d = tcpq_pkg::ST_FULL;
				end else begin
					count_next = count_q + tcpq_pkg::CNT_W'(1);
				end
			end
			tcpq_pkg::CMD_DEQ: begin
				if (empty) begin
					status_d = tcpq_pkg::ST_EMPTY;
				end else begin
					out_d      = sel;
					count_next = count_q - tcpq_pkg::CNT_W'(1);
				end
			end
			tcpq_pkg::CMD_CANCEL: begin
				if (found[D]) begin
					count_next = count_q - tcpq_pkg::CNT_W'(1);
				end else begin
					status_d = tcpq_pkg::ST_NOTFOUND;
				end
			end
			default: begin
				status_d = tcpq_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (exec) begin
			count_q     <= count_next;
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q <= status_d;
			out_q    <= out_d;
			live_q   <= tcpq_pkg::LIVE_W'(count_next);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.out_id     = out_q.id;
	assign rsp.out_prep   = out_q.prep;
	assign rsp.out_vip    = out_q.vip;
	assign rsp.live_count = live_q;

endmodule

`default_nettype wire

// ===== sv/tcpq_checker.sv =====
`default_nettype none

module tcpq_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              rsp_valid,
	input wire logic                              rsp_ready,
	input wire logic [1:0]                        status,
	input wire logic [tcpq_pkg::ID_W-1:0]         out_id,
	input wire logic                              out_vip,
	input wire logic [tcpq_pkg::LIVE_W-1:0]       live_count
);

	// A pending response transaction stays until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");

	// A full status means the queue holds every slot
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == tcpq_pkg::ST_FULL |->
			live_count == tcpq_pkg::LIVE_W'(tcpq_pkg::QUEUE_DEPTH))
		else $error("full status with free slots");

	// An empty dequeue reports no entry and an empty queue
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == tcpq_pkg::ST_EMPTY |->
			live_count == '0 && out_id == '0 && !out_vip)
		else $error("empty status with entry data or live entries");

	// A failed cancel reports no entry data
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == tcpq_pkg::ST_NOTFOUND |-> out_id == '0 && !out_vip)
		else $error("not-found status with entry data");

endmodule

bind two_class_priority_queue_cancel_top tcpq_checker u_tcpq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.out_id     (rsp.out_id),
	.out_vip    (rsp.out_vip),
	.live_count (rsp.live_count)
);

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcpq_pkg::*;

	localparam int RUN_LIMIT    = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 200;
	localparam int CALM_TAIL    = 100;
	localparam int RANDOM_ITEMS = 750;

	typedef struct {
		cmd_t              cmd;
		logic [ID_W-1:0]   id;
		logic [PREP_W-1:0] prep;
		logic              vip;
		int unsigned       gap;
	} order_t;

	typedef struct {
		status_t           status;
		logic [ID_W-1:0]   id;
		logic [PREP_W-1:0] prep;
		logic              vip;
		logic [LIVE_W-1:0] live;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	tcpq_req_if req();
	tcpq_rsp_if rsp();

	two_class_priority_queue_cancel_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Shadow copy of the queue slots
	logic              shadow_valid [QUEUE_DEPTH];
	logic [ID_W-1:0]   shadow_id    [QUEUE_DEPTH];
	logic [PREP_W-1:0] shadow_prep  [QUEUE_DEPTH];
	logic              shadow_vip   [QUEUE_DEPTH];
	logic [31:0]       shadow_stamp [QUEUE_DEPTH];
	logic [31:0]       stamp_next;

	order_t   order_q[$];
	outcome_t outcome_q[$];
	order_t   cur_order;

	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned hold_left;
	int unsigned window_left;
	bit          hold_done;
	bit          stall_on;
	int          rsp_count;
	int          mismatches;
	int          cycle_count;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Oldest live slot among those that pass the filters, -1 when none
	function automatic int oldest_entry(bit vip_only, bit by_id, logic [ID_W-1:0] key);
		int best;
		best = -1;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (shadow_valid[i] && (!vip_only || shadow_vip[i]) &&
					(!by_id || shadow_id[i] == key)) begin
				if (best < 0 ||
						(stamp_next - shadow_stamp[i]) > (stamp_next - shadow_stamp[best]))
					best = i;
			end
		end
		return best;
	endfunction

	// Apply one command to the shadow queue and return the response it should give
	function automatic outcome_t predict_queue_op(order_t o);
		outcome_t r;
		int slot;
		int live;
		r.status = ST_OK;
		r.id     = '0;
		r.prep   = '0;
		r.vip    = 1'b0;
		slot     = -1;
		case (o.cmd)
			CMD_ENQ: begin
				for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
					if (!shadow_valid[i])
						slot = i;
				if (slot < 0) begin
					r.status = ST_FULL;
				end else begin
					shadow_valid[slot] = 1'b1;
					shadow_id[slot]    = o.id;
					shadow_prep[slot]  = o.prep;
					shadow_vip[slot]   = o.vip;
					shadow_stamp[slot] = stamp_next;
					stamp_next         = stamp_next + 32'd1;
				end
			end
			CMD_DEQ: begin
				slot = oldest_entry(1'b1, 1'b0, '0);
				if (slot < 0)
					slot = oldest_entry(1'b0, 1'b0, '0);
				if (slot < 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.id               = shadow_id[slot];
					r.prep             = shadow_prep[slot];
					r.vip              = shadow_vip[slot];
					shadow_valid[slot] = 1'b0;
				end
			end
			CMD_CANCEL: begin
				slot = oldest_entry(1'b0, 1'b1, o.id);
				if (slot < 0)
					r.status = ST_NOTFOUND;
				else
					shadow_valid[slot] = 1'b0;
			end
			CMD_NOP: ;
		endcase
		live = 0;
		for (int i = 0; i < QUEUE_DEPTH; i++)
			live += shadow_valid[i];
		r.live = live[LIVE_W-1:0];
		return r;
	endfunction

	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic add_order(cmd_t cmd, logic [ID_W-1:0] id, logic [PREP_W-1:0] prep,
			logic vip, int unsigned gap);
		order_t o;
		o.cmd  = cmd;
		o.id   = id;
		o.prep = prep;
		o.vip  = vip;
		o.gap  = gap;
		order_q.insert(order_q.size(), o);
	endtask

	// Request driver: wait out the gap of the next order, then offer it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid     <= 1'b0;
			req.command   <= CMD_NOP;
			req.entry_id  <= '0;
			req.prep_time <= '0;
			req.vip       <= 1'b0;
			gap_left = 0;
		end else begin
			if (req.valid && req.ready)
				outcome_q.insert(outcome_q.size(), predict_queue_op(cur_order));
			if (!req.valid || req.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					req.valid <= 1'b0;
				end else if (order_q.size() != 0 && order_q[0].gap != 0) begin
					gap_left = order_q[0].gap - 1;
					order_q[0].gap = 0;
					req.valid <= 1'b0;
				end else if (order_q.size() != 0) begin
					cur_order = order_q.pop_front();
					req.valid     <= 1'b1;
					req.command   <= cur_order.cmd;
					req.entry_id  <= cur_order.id;
					req.prep_time <= cur_order.prep;
					req.vip       <= cur_order.vip;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left  = 0;
			hold_left   = 0;
			window_left = 0;
			hold_done   = 1'b0;
			stall_on    = 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_count++;
				if (outcome_q.size() == 0) begin
					$display("%0t ns: unexpected response, expected none, actual status %0d id %h",
						$time, rsp.status, rsp.out_id);
					mismatches++;
				end else begin
					outcome_t want;
					want = outcome_q.pop_front();
					compare_field("status", 16'(want.status), 16'(rsp.status));
					compare_field("out_id", want.id, rsp.out_id);
					compare_field("out_prep", want.prep, rsp.out_prep);
					compare_field("out_vip", 16'(want.vip), 16'(rsp.out_vip));
					compare_field("live_count", 16'(want.live), 16'(rsp.live_count));
				end
			end
			// Switch between stalling and free-running stretches
			if (window_left == 0) begin
				window_left = 50;
				stall_on = ($urandom_range(0, 2) != 0);
			end else begin
				window_left--;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (!hold_done && rsp_count >= HOLD_AT) begin
				// Long hold-off so the queue backs up into the request side
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rsp.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (stall_on && order_q.size() > CALM_TAIL &&
					$urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 5);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int          enq_pct;
		bit          idle_mode;
		int unsigned gap;
		int unsigned pick;
		cmd_t        cmd;
		logic [ID_W-1:0] id;

		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.command   = CMD_NOP;
		req.entry_id  = '0;
		req.prep_time = '0;
		req.vip       = 1'b0;
		rsp.ready     = 1'b0;
		rsp_count     = 0;
		mismatches    = 0;
		cycle_count   = 0;
		stamp_next    = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++)
			shadow_valid[i] = 1'b0;

		// Directed: empty queue, missing id, no-op, fill to full, duplicates, priority
		add_order(CMD_DEQ, 16'h0000, 16'h0000, 1'b0, 0);
		add_order(CMD_CANCEL, 16'h0005, 16'h0000, 1'b0, 0);
		add_order(CMD_NOP, 16'hFFFF, 16'hFFFF, 1'b1, 0);
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			id = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF :
				(k == 5 || k == 9) ? 16'h0007 : 16'(k * 3 + 100);
			add_order(CMD_ENQ, id, (k == 0) ? 16'hFFFF : 16'(k * 37), 1'(k % 3 == 1), 0);
		end
		add_order(CMD_ENQ, 16'h1234, 16'h5678, 1'b1, 0);
		add_order(CMD_CANCEL, 16'h0007, 16'h0000, 1'b0, 0);
		add_order(CMD_DEQ, 16'h0000, 16'h0000, 1'b0, 0);
		add_order(CMD_CANCEL, 16'hBEEF, 16'h0000, 1'b0, 0);
		add_order(CMD_ENQ, 16'hA5A5, 16'h5A5A, 1'b0, 0);
		add_order(CMD_DEQ, 16'h0000, 16'h0000, 1'b0, 0);

		// Random: phases that lean toward filling or draining, ids mostly from a small pool
		enq_pct   = 50;
		idle_mode = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				pick = $urandom_range(0, 2);
				enq_pct   = (pick == 0) ? 25 : (pick == 1) ? 50 : 80;
				idle_mode = ($urandom_range(0, 2) != 0);
			end
			if ($urandom_range(0, 99) < 3)
				cmd = CMD_NOP;
			else if ($urandom_range(0, 99) < enq_pct)
				cmd = CMD_ENQ;
			else if ($urandom_range(0, 3) == 0)
				cmd = CMD_CANCEL;
			else
				cmd = CMD_DEQ;
			id = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 23));
			gap = (idle_mode && n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) ?
				$urandom_range(1, 6) : 0;
			add_order(cmd, id, 16'($urandom()), 1'($urandom_range(0, 1)), gap);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Drain everything, then give the block time to show any stray response
		while (order_q.size() != 0 || req.valid || outcome_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== two_class_priority_queue_cancel_top.f =====
sv/tcpq_pkg.sv
sv/tcpq_req_if.sv
sv/tcpq_rsp_if.sv
sv/tcpq_cell.sv
sv/two_class_priority_queue_cancel_top.sv
sv/tcpq_checker.sv
tb/tb.sv
